[hw/rtl/framebuffer_rect_fill_assert.svh]
// Assertion macros shared by the framebuffer fill engine RTL.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef FRAMEBUFFER_RECT_FILL_ASSERT_SVH
`define FRAMEBUFFER_RECT_FILL_ASSERT_SVH

// Checked on every rising edge while the block is out of reset.
`define FBRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define FBRF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hw/rtl/fbrf_pkg.sv]
// Shared types and constants for the framebuffer fill engine.
// Has no dependencies; used by framebuffer_rect_fill.
package fbrf_pkg;

  // Command codes carried in the func field.
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_FILL  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 8'd1;

  // Screen coordinates and sizes after clipping fit the 7-bit registers.
  localparam int unsigned CRD_W   = 7;
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned PIXEL_W = 32;

  // Input word layout, lowest field first.
  localparam int unsigned FUNC_LSB  = 0;
  localparam int unsigned PX_LSB    = FUNC_LSB + FUNC_W;
  localparam int unsigned PY_LSB    = PX_LSB + POS_W;
  localparam int unsigned RW_LSB    = PY_LSB + POS_W;
  localparam int unsigned RH_LSB    = RW_LSB + POS_W;
  localparam int unsigned COLOR_LSB = RH_LSB + POS_W;
  localparam int unsigned IN_BITS   = COLOR_LSB + PIXEL_W;
  localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_WIPE,
    ST_IDLE,
    ST_MUL,
    ST_ADDX,
    ST_RD_REQ,
    ST_RD_DATA,
    ST_FILL,
    ST_DONE
  } state_e;

endpackage

[hw/rtl/framebuffer_rect_fill.sv]
// Framebuffer fill engine over a MAX_WIDTH x MAX_HEIGHT store of 32-bit pixels,
// the pixel (x,y) held at y * width + x. After reset the whole store is wiped
// to zero, during which no command word is taken; configuration writes are
// taken at any time. Commands run one at a time through a single shared adder
// under a small sequencer: the row offset is built by a shift-add multiply of
// seven steps, then one step adds the column. A read then issues its request to
// the store and registers the data before it returns its result word. A fill
// writes the clipped rectangle and a clear the whole width x height screen, as
// the single RAM port writes one pixel per cycle. A read off screen, an empty
// fill or clear, or an unused command skips the sequencer and returns its zero
// word. Every command returns exactly one result word; the result register lets
// the next command be accepted while that word is still waiting.
`include "framebuffer_rect_fill_assert.svh"

module framebuffer_rect_fill #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Command words
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // func[1:0], pos_x[17:2], pos_y[33:18], rect_w[49:34], rect_h[65:50],
  // fill_color[97:66], zero pad[103:98]
  input  logic [fbrf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // Result words
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // read_data[31:0]
  output logic [fbrf_pkg::PIXEL_W-1:0]     m_axis_tdata,
  // Configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [fbrf_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fbrf_pkg::CRD_W-1:0]       cfg_data_i
);

  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ACC_W  = ADDR_W + 1;
  localparam int unsigned CRD_W  = fbrf_pkg::CRD_W;
  localparam int unsigned POS_W  = fbrf_pkg::POS_W;
  localparam int unsigned PIX_W  = fbrf_pkg::PIXEL_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  fbrf_pkg::state_e state_q, state_d;

  // Configuration
  logic [CRD_W-1:0] width_q, height_q;
  logic [CRD_W-1:0] w_eff, h_eff;
  logic [ACC_W-1:0] w_ext;

  // Sequencer datapath
  logic [ACC_W-1:0] acc_q, acc_d, row_q, row_d;
  logic [ACC_W-1:0] add_a, add_b, add_sum;
  logic [2:0]       bit_q, bit_d;
  logic [CRD_W-1:0] px_q, px_d, py_q, py_d;
  logic [CRD_W-1:0] cols_q, cols_d, xl_q, xl_d, yl_q, yl_d;
  logic             is_read_q, is_read_d;
  logic [PIX_W-1:0] color_q, color_d, res_q, res_d;
  logic             mval_q, mval_d;
  logic [PIX_W-1:0] mdata_q, mdata_d;

  // Command decode
  logic             in_acc, out_free;
  logic [1:0]       in_func;
  logic [POS_W-1:0] in_px, in_py, in_rw, in_rh;
  logic [PIX_W-1:0] in_color;
  logic             on_x, on_y;
  logic [CRD_W-1:0] w_rem, h_rem;
  logic             dec_go, dec_read;
  logic [CRD_W-1:0] dec_px, dec_py, dec_cols, dec_rows;

  // Pixel store port
  logic              ram_we;
  logic [PIX_W-1:0]  ram_wdata, ram_rdata;

  assign w_eff = (int'(width_q) > int'(MAX_WIDTH)) ? CRD_W'(MAX_WIDTH) : width_q;
  assign h_eff = (int'(height_q) > int'(MAX_HEIGHT)) ? CRD_W'(MAX_HEIGHT) : height_q;
  assign w_ext = ACC_W'(w_eff);

  assign s_axis_tready = (state_q == fbrf_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !mval_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign in_func  = s_axis_tdata[fbrf_pkg::FUNC_LSB +: fbrf_pkg::FUNC_W];
  assign in_px    = s_axis_tdata[fbrf_pkg::PX_LSB +: POS_W];
  assign in_py    = s_axis_tdata[fbrf_pkg::PY_LSB +: POS_W];
  assign in_rw    = s_axis_tdata[fbrf_pkg::RW_LSB +: POS_W];
  assign in_rh    = s_axis_tdata[fbrf_pkg::RH_LSB +: POS_W];
  assign in_color = s_axis_tdata[fbrf_pkg::COLOR_LSB +: PIX_W];

  // The corner is compared in full width; once it is on screen its low bits
  // suffice, and the span is clipped against the room left to the edge.
  assign on_x  = in_px < POS_W'(w_eff);
  assign on_y  = in_py < POS_W'(h_eff);
  assign w_rem = w_eff - in_px[CRD_W-1:0];
  assign h_rem = h_eff - in_py[CRD_W-1:0];

  always_comb begin
    dec_go   = 1'b0;
    dec_read = 1'b0;
    dec_px   = in_px[CRD_W-1:0];
    dec_py   = in_py[CRD_W-1:0];
    dec_cols = (in_rw > POS_W'(w_rem)) ? w_rem : in_rw[CRD_W-1:0];
    dec_rows = (in_rh > POS_W'(h_rem)) ? h_rem : in_rh[CRD_W-1:0];
    unique case (in_func)
      fbrf_pkg::FUNC_READ: begin
        dec_go   = on_x && on_y;
        dec_read = 1'b1;
      end
      fbrf_pkg::FUNC_FILL: begin
        dec_go = on_x && on_y && (in_rw != '0) && (in_rh != '0);
      end
      fbrf_pkg::FUNC_CLEAR: begin
        dec_go   = (w_eff != '0) && (h_eff != '0);
        dec_px   = '0;
        dec_py   = '0;
        dec_cols = w_eff;
        dec_rows = h_eff;
      end
      default: begin
        dec_go = 1'b0;
      end
    endcase
  end

  // The one adder that every address step goes through.
  assign add_sum = add_a + add_b;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fbrf_pkg::ST_WIPE: begin
        if (acc_q[ADDR_W-1:0] == LAST_ADDR) state_d = fbrf_pkg::ST_IDLE;
      end
      fbrf_pkg::ST_IDLE: begin
        if (in_acc) state_d = dec_go ? fbrf_pkg::ST_MUL : fbrf_pkg::ST_DONE;
      end
      fbrf_pkg::ST_MUL: begin
        if (bit_q == '0) state_d = fbrf_pkg::ST_ADDX;
      end
      fbrf_pkg::ST_ADDX: begin
        state_d = is_read_q ? fbrf_pkg::ST_RD_REQ : fbrf_pkg::ST_FILL;
      end
      fbrf_pkg::ST_RD_REQ:  state_d = fbrf_pkg::ST_RD_DATA;
      fbrf_pkg::ST_RD_DATA: state_d = fbrf_pkg::ST_DONE;
      fbrf_pkg::ST_FILL: begin
        if (xl_q == CRD_W'(1) && yl_q == CRD_W'(1)) state_d = fbrf_pkg::ST_DONE;
      end
      fbrf_pkg::ST_DONE: begin
        if (out_free) state_d = fbrf_pkg::ST_IDLE;
      end
      default: state_d = fbrf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    acc_d     = acc_q;
    row_d     = row_q;
    bit_d     = bit_q;
    px_d      = px_q;
    py_d      = py_q;
    cols_d    = cols_q;
    xl_d      = xl_q;
    yl_d      = yl_q;
    is_read_d = is_read_q;
    color_d   = color_q;
    res_d     = res_q;
    mval_d    = mval_q && !m_axis_tready;
    mdata_d   = mdata_q;
    add_a     = acc_q;
    add_b     = '0;
    ram_we    = 1'b0;
    ram_wdata = color_q;
    unique case (state_q)
      fbrf_pkg::ST_WIPE: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        add_b     = ACC_W'(1);
        acc_d     = add_sum;
      end
      fbrf_pkg::ST_IDLE: begin
        if (in_acc) begin
          acc_d     = '0;
          bit_d     = 3'(CRD_W - 1);
          px_d      = dec_px;
          py_d      = dec_py;
          cols_d    = dec_cols;
          xl_d      = dec_cols;
          yl_d      = dec_rows;
          is_read_d = dec_read;
          color_d   = in_color;
          res_d     = '0;
        end
      end
      fbrf_pkg::ST_MUL: begin
        // Shift-add multiply, most significant bit of the row first.
        add_a = acc_q << 1;
        add_b = py_q[bit_q] ? w_ext : '0;
        acc_d = add_sum;
        bit_d = bit_q - 3'd1;
      end
      fbrf_pkg::ST_ADDX: begin
        add_b = ACC_W'(px_q);
        acc_d = add_sum;
        row_d = add_sum;
      end
      fbrf_pkg::ST_RD_REQ: begin
        acc_d = acc_q;
      end
      fbrf_pkg::ST_RD_DATA: begin
        res_d = ram_rdata;
      end
      fbrf_pkg::ST_FILL: begin
        ram_we = 1'b1;
        if (xl_q == CRD_W'(1)) begin
          // End of a row: step the row start down by one screen width.
          add_a = row_q;
          add_b = w_ext;
          acc_d = add_sum;
          row_d = add_sum;
          xl_d  = cols_q;
          yl_d  = yl_q - CRD_W'(1);
        end else begin
          add_b = ACC_W'(1);
          acc_d = add_sum;
          xl_d  = xl_q - CRD_W'(1);
        end
      end
      fbrf_pkg::ST_DONE: begin
        if (out_free) begin
          mval_d  = 1'b1;
          mdata_d = res_q;
        end
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fbrf_pkg::ST_WIPE;
      acc_q    <= '0;
      mval_q   <= 1'b0;
      width_q  <= CRD_W'(64);
      height_q <= CRD_W'(64);
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      mval_q  <= mval_d;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == fbrf_pkg::CFG_SCREEN_WIDTH) width_q <= cfg_data_i;
        if (cfg_index_i == fbrf_pkg::CFG_SCREEN_HEIGHT) height_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q     <= row_d;
    bit_q     <= bit_d;
    px_q      <= px_d;
    py_q      <= py_d;
    cols_q    <= cols_d;
    xl_q      <= xl_d;
    yl_q      <= yl_d;
    is_read_q <= is_read_d;
    color_q   <= color_d;
    res_q     <= res_d;
    mdata_q   <= mdata_d;
  end

  fbrf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (acc_q[ADDR_W-1:0]),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = mdata_q;

  `FBRF_ASSERT(a_we_states,
    ram_we |-> (state_q == fbrf_pkg::ST_FILL || state_q == fbrf_pkg::ST_WIPE),
    "store written outside a fill or wipe")
  `FBRF_ASSERT(a_fill_in_screen,
    (state_q == fbrf_pkg::ST_FILL) |-> (32'(acc_q) < 32'(w_eff) * 32'(h_eff)),
    "fill address beyond the screen")
  `FBRF_ASSERT(a_accept_leaves_idle, in_acc |=> (state_q != fbrf_pkg::ST_IDLE),
    "command accepted but sequencer stayed idle")
  `FBRF_ASSERT(a_read_follows_req,
    (state_q == fbrf_pkg::ST_RD_DATA) |-> ($past(state_q) == fbrf_pkg::ST_RD_REQ),
    "read data taken without a request")
  `FBRF_ASSERT_ALWAYS(a_no_accept_in_reset, !rst_ni |-> !in_acc,
    "command word taken during reset")

endmodule

[hw/rtl/fbrf_ram.sv]
// Generic single-port RAM with a registered read, one access per cycle.
// Has no dependencies; used for the pixel store.
module fbrf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[tb/sv/tb_framebuffer_rect_fill.sv]
`timescale 1ns / 1ps
// Self-checking testbench for framebuffer_rect_fill: reads, clipped fills and clears against
// a behavioural pixel store, under several screen sizes. Depends on fbrf_pkg and the block.
module tb_framebuffer_rect_fill;

  localparam int unsigned FUNC_W     = fbrf_pkg::FUNC_W;
  localparam int unsigned POS_W      = fbrf_pkg::POS_W;
  localparam int unsigned PIXEL_W    = fbrf_pkg::PIXEL_W;
  localparam int unsigned CRD_W      = fbrf_pkg::CRD_W;
  localparam int unsigned CFG_IDX_W  = fbrf_pkg::CFG_IDX_W;
  localparam int unsigned IN_TDATA_W = fbrf_pkg::IN_TDATA_W;

  localparam logic [FUNC_W-1:0]    FUNC_READ         = fbrf_pkg::FUNC_READ;
  localparam logic [FUNC_W-1:0]    FUNC_FILL         = fbrf_pkg::FUNC_FILL;
  localparam logic [FUNC_W-1:0]    FUNC_CLEAR        = fbrf_pkg::FUNC_CLEAR;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = fbrf_pkg::CFG_SCREEN_WIDTH;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = fbrf_pkg::CFG_SCREEN_HEIGHT;

  localparam int unsigned FB_MAX_W = 64;
  localparam int unsigned FB_MAX_H = 64;
  localparam int unsigned FB_DEPTH = FB_MAX_W * FB_MAX_H;
  localparam int unsigned FB_AW    = $clog2(FB_DEPTH);
  localparam int unsigned PAD_W    = IN_TDATA_W - fbrf_pkg::IN_BITS;

  // The block treats this code as a no-op that still returns a zero word.
  localparam logic [1:0]           FUNC_NONE   = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BAD_IDX = 8'hFF;

  localparam int unsigned PHASES     = 8;
  localparam int unsigned PHASE_CMDS = 50;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [POS_W-1:0]   px;
    logic [POS_W-1:0]   py;
    logic [POS_W-1:0]   rw;
    logic [POS_W-1:0]   rh;
    logic [PIXEL_W-1:0] color;
  } fb_cmd_t;

  typedef struct packed {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] cidx;
    logic [CRD_W-1:0]     cdata;
    fb_cmd_t              cmd;
    bit                   has_want;
    logic [PIXEL_W-1:0]   want;
  } dir_row_t;

  typedef struct {
    logic [PIXEL_W-1:0] data;
    int unsigned        seq;
  } pixel_exp_t;

  localparam int unsigned DIR_N = 26;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{1'b0, '0, '0, '{FUNC_READ, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0}, 1'b1, 32'h0},
    '{1'b0, '0, '0, '{FUNC_READ, 16'd63, 16'd63, 16'd0, 16'd0, 32'h0}, 1'b1, 32'h0},
    '{1'b0, '0, '0, '{FUNC_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF},
      1'b1, 32'h0},
    '{1'b0, '0, '0, '{FUNC_FILL, 16'd0, 16'd0, 16'd1, 16'd1, 32'hFFFF_FFFF}, 1'b1, 32'h0},
    '{1'b0, '0, '0, '{FUNC_READ, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0}, 1'b1, 32'hFFFF_FFFF},
    '{1'b0, '0, '0, '{FUNC_FILL, 16'd60, 16'd62, 16'hFFFF, 16'hFFFF, 32'hA5A5_A5A5},
      1'b1, 32'h0},
    '{1'b0, '0, '0, '{FUNC_READ, 16'd63, 16'd63, 16'd0, 16'd0, 32'h0}, 1'b0, 32'h0},
    '{1'b0, '0, '0, '{FUNC_READ, 16'd59, 16'd63, 16'd0, 16'd0, 32'h0}, 1'b0, 32'h0},
    '{1'b0, '0, '0, '{FUNC_FILL, 16'd0, 16'd0, 16'd0, 16'd5, 32'h1234_5678}, 1'b1, 32'h0},
    '{1'b0, '0, '0, '{FUNC_FILL, 16'd3, 16'd3, 16'd5, 16'd0, 32'h1234_5678}, 1'b1, 32'h0},
    '{1'b0, '0, '0, '{FUNC_FILL, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0},
      1'b1, 32'h0},
    '{1'b0, '0, '0, '{FUNC_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF},
      1'b1, 32'h0},
    '{1'b0, '0, '0, '{FUNC_READ, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0}, 1'b1, 32'hFFFF_FFFF},
    '{1'b0, '0, '0, '{FUNC_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 32'h5A5A_5A5A}, 1'b1, 32'h0},
    '{1'b0, '0, '0, '{FUNC_READ, 16'd31, 16'd17, 16'd0, 16'd0, 32'h0}, 1'b0, 32'h0},
    '{1'b0, '0, '0, '{FUNC_FILL, 16'd2, 16'd3, 16'd4, 16'd5, 32'h0F0F_0F0F}, 1'b1, 32'h0},
    '{1'b1, CFG_SCREEN_WIDTH, 7'd0, '0, 1'b0, 32'h0},
    '{1'b0, '0, '0, '{FUNC_READ, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0}, 1'b1, 32'h0},
    '{1'b0, '0, '0, '{FUNC_FILL, 16'd0, 16'd0, 16'd10, 16'd10, 32'h0000_0001}, 1'b1, 32'h0},
    '{1'b0, '0, '0, '{FUNC_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_0002}, 1'b1, 32'h0},
    '{1'b1, CFG_SCREEN_WIDTH, 7'd127, '0, 1'b0, 32'h0},
    '{1'b0, '0, '0, '{FUNC_READ, 16'd4, 16'd5, 16'd0, 16'd0, 32'h0}, 1'b0, 32'h0},
    '{1'b1, CFG_BAD_IDX, 7'h55, '0, 1'b0, 32'h0},
    '{1'b1, CFG_SCREEN_WIDTH, 7'd10, '0, 1'b0, 32'h0},
    '{1'b1, CFG_SCREEN_HEIGHT, 7'd127, '0, 1'b0, 32'h0},
    '{1'b0, '0, '0, '{FUNC_READ, 16'd4, 16'd25, 16'd0, 16'd0, 32'h0}, 1'b0, 32'h0}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [PIXEL_W-1:0]    m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CRD_W-1:0]      cfg_data_i = '0;

  // Behavioural copy of the pixel store and the two screen registers.
  bit   [PIXEL_W-1:0] fb_mem [FB_DEPTH];
  logic [CRD_W-1:0]   scr_w = 7'd64;
  logic [CRD_W-1:0]   scr_h = 7'd64;

  pixel_exp_t  pix_exp_q [$];
  pixel_exp_t  head;
  int unsigned cmd_seq = 0;
  int unsigned err_cnt = 0;
  bit          steady_flow = 1'b0;

  framebuffer_rect_fill #(
    .MAX_WIDTH (FB_MAX_W),
    .MAX_HEIGHT(FB_MAX_H)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned eff_w();
    return (32'(scr_w) > FB_MAX_W) ? FB_MAX_W : 32'(scr_w);
  endfunction

  function automatic int unsigned eff_h();
    return (32'(scr_h) > FB_MAX_H) ? FB_MAX_H : 32'(scr_h);
  endfunction

  // Applies one command to the pixel store and returns the word it should produce.
  function automatic logic [PIXEL_W-1:0] fb_exec(fb_cmd_t c);
    int unsigned ew, eh, px, py, x_end, y_end;
    logic [PIXEL_W-1:0] rd;
    ew = eff_w();
    eh = eff_h();
    px = 32'(c.px);
    py = 32'(c.py);
    rd = '0;
    case (c.func)
      FUNC_READ: begin
        if (px < ew && py < eh) rd = fb_mem[FB_AW'(py * ew + px)];
      end
      FUNC_FILL: begin
        x_end = px + 32'(c.rw);
        y_end = py + 32'(c.rh);
        if (x_end > ew) x_end = ew;
        if (y_end > eh) y_end = eh;
        for (int unsigned y = py; y < y_end; y++)
          for (int unsigned x = px; x < x_end; x++) fb_mem[FB_AW'(y * ew + x)] = c.color;
      end
      FUNC_CLEAR: begin
        for (int unsigned i = 0; i < ew * eh; i++) fb_mem[FB_AW'(i)] = c.color;
      end
      default: ;
    endcase
    return rd;
  endfunction

  // Mostly on-screen coordinates and small rectangles, with a few wild words so that
  // every bit of every field toggles and clipping gets exercised.
  function automatic fb_cmd_t rand_cmd();
    fb_cmd_t c;
    int unsigned pick;
    pick    = $urandom_range(0, 99);
    c.color = $urandom();
    c.px    = POS_W'($urandom_range(0, eff_w() + 1));
    c.py    = POS_W'($urandom_range(0, eff_h() + 1));
    c.rw    = POS_W'($urandom_range(0, 6));
    c.rh    = POS_W'($urandom_range(0, 6));
    if (pick < 45) c.func = FUNC_READ;
    else if (pick < 85) c.func = FUNC_FILL;
    else if (pick < 90) c.func = FUNC_CLEAR;
    else c.func = FUNC_NONE;
    if ($urandom_range(0, 99) < 8) begin
      c.px = POS_W'($urandom());
      c.py = POS_W'($urandom());
    end
    if ($urandom_range(0, 99) < 8) begin
      c.rw = POS_W'($urandom());
      c.rh = POS_W'($urandom());
    end else if ($urandom_range(0, 99) < 12) begin
      c.rw = POS_W'($urandom_range(0, 70));
      c.rh = POS_W'($urandom_range(0, 70));
    end
    return c;
  endfunction

  task automatic push_cmd(input fb_cmd_t c, input bit has_want, input logic [PIXEL_W-1:0] want);
    pixel_exp_t e;
    logic [PIXEL_W-1:0] pred;
    while (!steady_flow && $urandom_range(0, 99) < 30) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{PAD_W{1'b0}}, c.color, c.rh, c.rw, c.py, c.px, c.func};
    do @(posedge clk_i); while (!s_axis_tready);
    pred   = fb_exec(c);
    e.data = has_want ? want : pred;
    e.seq  = cmd_seq;
    cmd_seq++;
    pix_exp_q.push_back(e);
  endtask

  // Drops the command valid and waits until every outstanding word has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pix_exp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CRD_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_SCREEN_WIDTH) scr_w = val;
    else if (idx == CFG_SCREEN_HEIGHT) scr_h = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= 30);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pix_exp_q.size() == 0) begin
        if (err_cnt < 10) $display("unexpected result word %h", m_axis_tdata);
        err_cnt++;
      end else begin
        head = pix_exp_q.pop_front();
        if (m_axis_tdata !== head.data) begin
          if (err_cnt < 10)
            $display("command %0d: read_data expected %h, got %h",
                     head.seq, head.data, m_axis_tdata);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    logic [CRD_W-1:0] pw [PHASES] = '{7'd64, 7'd1, 7'd127, 7'd16, 7'd64, 7'd5, 7'd0, 7'd0};
    logic [CRD_W-1:0] ph [PHASES] = '{7'd64, 7'd1, 7'd127, 7'd3, 7'd1, 7'd0, 7'd0, 7'd0};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned r = 0; r < DIR_N; r++) begin
      if (DIR_TAB[r].is_cfg) begin
        wait_drained();
        write_reg(DIR_TAB[r].cidx, DIR_TAB[r].cdata);
      end else begin
        push_cmd(DIR_TAB[r].cmd, DIR_TAB[r].has_want, DIR_TAB[r].want);
      end
    end

    // The last two phases pick their screen sizes at random.
    for (int unsigned p = 0; p < PHASES; p++) begin
      wait_drained();
      if (p >= PHASES - 2) begin
        pw[p] = CRD_W'($urandom_range(0, 127));
        ph[p] = CRD_W'($urandom_range(0, 127));
      end
      write_reg(CFG_SCREEN_WIDTH, pw[p]);
      write_reg(CFG_SCREEN_HEIGHT, ph[p]);
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(2, 255)), CRD_W'($urandom()));
      steady_flow = (p == 2);
      for (int n = 0; n < PHASE_CMDS; n++) push_cmd(rand_cmd(), 1'b0, '0);
    end

    steady_flow = 1'b0;
    wait_drained();
    repeat (16) @(posedge clk_i);
    if (err_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/fbrf_pkg.sv
hw/rtl/fbrf_ram.sv
hw/rtl/framebuffer_rect_fill.sv
tb/sv/tb_framebuffer_rect_fill.sv
